[design/mrgs_pkg.sv]
`default_nettype none

package mrgs_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // input word taken
    logic start;       // input word taken and it closes the batch
    logic setup;       // open the next merge segment
    logic merge;       // one merge step
    logic emit;        // read port follows the emit pointer
    logic emit_prime;  // rewind the emit pointer
    logic emit_adv;    // output word taken
    logic clear;       // batch done
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;    // buffer still empty
    logic seg_end;     // this merge step writes the last word of the segment
    logic pass_end;    // current segment is the last of the pass
    logic sort_end;    // the run after this pass covers the whole batch
    logic emit_last;   // word on the output is the last of the batch
  } sts_t;

endpackage

`default_nettype wire

[design/mrgs_dpath.sv]
`default_nettype none

module mrgs_dpath #(
  parameter int MAX_LEN    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mrgs_pkg::cmd_t        cmd_i,
  input  wire logic [DATA_WIDTH-1:0] in_value_i,
  output mrgs_pkg::sts_t             sts_o,
  output logic [DATA_WIDTH-1:0]      out_value_o,
  output logic                       overflow_o
);
  import mrgs_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int RW = CW + 1;
  localparam int SW = CW + 2;

  logic [DATA_WIDTH-1:0] mem_a [MAX_LEN];
  logic [DATA_WIDTH-1:0] mem_b [MAX_LEN];
  logic [DATA_WIDTH-1:0] rd_a_i_q, rd_a_j_q, rd_b_i_q, rd_b_j_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          src_q, src_d;
  logic [RW-1:0] run_q, run_d;
  logic [CW-1:0] lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  logic [SW-1:0]         sum_mid, sum_hi;
  logic [CW-1:0]         mid_calc, hi_calc;
  logic [DATA_WIDTH-1:0] rd_i, rd_j, merge_word, wd_a;
  logic                  take_left, has_room;
  logic                  we_a, we_b;
  logic [AW-1:0]         wa_a, addr_i, addr_j;

  assign rd_i = src_q ? rd_b_i_q : rd_a_i_q;
  assign rd_j = src_q ? rd_b_j_q : rd_a_j_q;

  // segment bounds clipped to the batch length
  assign sum_mid  = SW'(lo_q) + SW'(run_q);
  assign sum_hi   = SW'(lo_q) + (SW'(run_q) << 1);
  assign mid_calc = (sum_mid > SW'(cnt_q)) ? cnt_q : sum_mid[CW-1:0];
  assign hi_calc  = (sum_hi > SW'(cnt_q)) ? cnt_q : sum_hi[CW-1:0];

  always_comb begin
    if (!(i_q < mid_q)) begin
      take_left = 1'b0;
    end else if (!(j_q < hi_q)) begin
      take_left = 1'b1;
    end else begin
      take_left = $signed(rd_i) <= $signed(rd_j);
    end
  end

  assign merge_word = take_left ? rd_i : rd_j;
  assign has_room   = cnt_q < CW'(MAX_LEN);

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    src_d = src_q;
    run_d = run_q;
    lo_d  = lo_q;
    mid_d = mid_q;
    hi_d  = hi_q;
    i_d   = i_q;
    j_d   = j_q;
    k_d   = k_q;
    if (cmd_i.load) begin
      if (has_room) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.start) begin
      run_d = RW'(1);
      lo_d  = '0;
    end
    if (cmd_i.setup) begin
      mid_d = mid_calc;
      hi_d  = hi_calc;
      i_d   = lo_q;
      j_d   = mid_calc;
      k_d   = lo_q;
    end
    if (cmd_i.merge) begin
      k_d = k_q + CW'(1);
      if (take_left) begin
        i_d = i_q + CW'(1);
      end else begin
        j_d = j_q + CW'(1);
      end
      if (sts_o.seg_end) begin
        if (sts_o.pass_end) begin
          run_d = run_q << 1;
          lo_d  = '0;
          src_d = ~src_q;
        end else begin
          lo_d = hi_q;
        end
      end
    end
    if (cmd_i.emit_prime) begin
      k_d = '0;
    end
    if (cmd_i.emit_adv) begin
      k_d = k_q + CW'(1);
    end
    if (cmd_i.clear) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      src_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      src_q <= 1'b0;
      run_q <= RW'(1);
      lo_q  <= '0;
      mid_q <= '0;
      hi_q  <= '0;
      i_q   <= '0;
      j_q   <= '0;
      k_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      src_q <= src_d;
      run_q <= run_d;
      lo_q  <= lo_d;
      mid_q <= mid_d;
      hi_q  <= hi_d;
      i_q   <= i_d;
      j_q   <= j_d;
      k_q   <= k_d;
    end
  end

  // read addresses follow the next pointers so the registered read data lines up with the current pointers
  assign addr_i = cmd_i.emit ? k_d[AW-1:0] : i_d[AW-1:0];
  assign addr_j = j_d[AW-1:0];

  // ping-pong buffers: loads go to a, each pass writes the other one
  assign we_a = (cmd_i.load && has_room) || (cmd_i.merge && src_q);
  assign wa_a = cmd_i.load ? cnt_q[AW-1:0] : k_q[AW-1:0];
  assign wd_a = cmd_i.load ? in_value_i : merge_word;
  assign we_b = cmd_i.merge && !src_q;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    rd_a_i_q <= mem_a[addr_i];
    rd_a_j_q <= mem_a[addr_j];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[k_q[AW-1:0]] <= merge_word;
    end
    rd_b_i_q <= mem_b[addr_i];
    rd_b_j_q <= mem_b[addr_j];
  end

  assign sts_o.cnt_zero  = cnt_q == '0;
  assign sts_o.seg_end   = (k_q + CW'(1)) == hi_q;
  assign sts_o.pass_end  = hi_q == cnt_q;
  assign sts_o.sort_end  = (SW'(run_q) << 1) >= SW'(cnt_q);
  assign sts_o.emit_last = (k_q + CW'(1)) == cnt_q;

  assign out_value_o = rd_i;
  assign overflow_o  = ovf_q;

endmodule

`default_nettype wire

[design/mrgs_ctrl.sv]
`default_nettype none

module mrgs_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire mrgs_pkg::sts_t sts_i,
  output mrgs_pkg::cmd_t      cmd_o
);
  import mrgs_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MERGE = 3'd2;
  localparam logic [2:0] ST_PRIME = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.start = 1'b1;
          // a batch of one word needs no merging
          state_d = sts_i.cnt_zero ? ST_PRIME : ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_MERGE;
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        if (sts_i.seg_end) begin
          state_d = (sts_i.pass_end && sts_i.sort_end) ? ST_PRIME : ST_SETUP;
        end
      end
      ST_PRIME: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_prime = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit     = 1'b1;
        out_valid_o    = 1'b1;
        cmd_o.emit_adv = out_ready_i;
        if (out_ready_i && sts_i.emit_last) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/merge_sort_batch_core.sv]
`default_nettype none

// channel  dir  tdata                  tlast        tuser
// s_axis   in   value                  last         -
// m_axis   out  value_res              last_res     overflow
//
// loading: tready stays high while a batch is collected; the word marked last starts the sort
// sorting: ping-pong bottom-up merge, one word per cycle with a setup state before each
//   segment; a full batch of 64 takes 6 passes
// emission: a priming state first, then one word per cycle; m_axis stalls hold the word
// no input is taken from the last input word until the last sorted word leaves
// reset clears the control state only, the buffers are not cleared
module merge_sort_batch_core #(
  parameter int MAX_LEN    = 64,
  parameter int DATA_WIDTH = 32,
  localparam int TDW       = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire logic [TDW-1:0] s_axis_tdata_i,   // value
  input  wire logic           s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic [TDW-1:0]      m_axis_tdata_o,   // value_res
  output logic                m_axis_tlast_o,
  output logic                m_axis_tuser_o    // overflow
);
  import mrgs_pkg::*;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [DATA_WIDTH-1:0] out_value;

  mrgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mrgs_dpath #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_value_i  (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .sts_o       (sts),
    .out_value_o (out_value),
    .overflow_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = TDW'(out_value);
  assign m_axis_tlast_o = m_axis_tvalid_o && sts.emit_last;

`ifndef ASSERT_OFF
  a_load_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while a result is offered");

  a_last_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input still open after the batch closed");

  a_last_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("not ready for a new batch after the last result");

  a_merge_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.merge |-> sts.pass_end || !sts.cnt_zero)
    else $error("merging an empty batch");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN       = 64;
  localparam int DATA_WIDTH    = 32;
  localparam int RANDOM_WORDS  = 190;
  localparam int QUIET_WORDS   = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int REPORT_MAX    = 10;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  // one word on the output side
  typedef struct packed {
    elem_t word_val;
    logic  word_last;
    logic  word_ovf;
  } sorted_word_t;

  typedef struct {
    elem_t value;
    bit    last;
    bit    typed;
    elem_t exp_val;
    bit    exp_last;
    bit    exp_ovf;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  merge_sort_batch_core #(
    .MAX_LEN(MAX_LEN),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_data),
    .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tlast_o(m_axis_tlast_o),
    .m_axis_tuser_o(m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // batch being collected, and the sorted words still owed by the block
  elem_t        batch_q[$];
  bit           batch_ovf = 1'b0;
  sorted_word_t sorted_q[$];

  int mismatch_cnt = 0;
  int idle_pct = 0;
  bit quiet = 1'b0;

  // single-word batches carry their answer; the rest go through the predictor
  stim_row_t directed_rows [19] = '{
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'h0000_0005, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'hFFFF_FFFB, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0003, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'hFFFF_FFFE, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, '0, 1'b0, 1'b0}
  };

  // collect one word; the closing word sorts the batch and queues its output
  task automatic absorb_word(input elem_t v, input bit l, input bit typed,
                             input sorted_word_t typed_word);
    elem_t        vals[$];
    elem_t        key;
    int           j;
    int           n;
    sorted_word_t w;
    if (batch_q.size() < MAX_LEN) begin
      batch_q.push_back(v);
    end else begin
      batch_ovf = 1'b1;
    end
    if (l) begin
      vals = batch_q;
      n = vals.size();
      for (int i = 1; i < n; i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      if (typed) begin
        sorted_q.push_back(typed_word);
      end else begin
        for (int k = 0; k < n; k++) begin
          w.word_val  = vals[k];
          w.word_last = (k == n - 1);
          w.word_ovf  = batch_ovf;
          sorted_q.push_back(w);
        end
      end
      batch_q.delete();
      batch_ovf = 1'b0;
    end
  endtask

  task automatic send_word(input elem_t v, input bit l, input bit typed,
                           input sorted_word_t typed_word);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= v;
    s_last  <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    absorb_word(v, l, typed, typed_word);
  endtask

  // extremes, a narrow band that repeats values, and full-range noise
  function automatic elem_t pick_value();
    elem_t v;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
      1: v = elem_t'($urandom_range(0, 8)) - 4;
      default: v = elem_t'($urandom());
    endcase
    return v;
  endfunction

  // sink side: random stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      if (stall_left == 0) m_ready <= 1'b1;
    end else if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 11);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  // output checker
  always @(posedge clk_i) begin
    sorted_word_t w;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (sorted_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word value=%0d last=%0b ovf=%0b",
                      $signed(m_axis_tdata_o), m_axis_tlast_o, m_axis_tuser_o));
      end else begin
        w = sorted_q.pop_front();
        if (elem_t'(m_axis_tdata_o) !== w.word_val)
          note_mismatch($sformatf("value exp=%0d got=%0d", w.word_val,
                        $signed(m_axis_tdata_o)));
        if (m_axis_tlast_o !== w.word_last)
          note_mismatch($sformatf("last exp=%0b got=%0b value=%0d", w.word_last,
                        m_axis_tlast_o, w.word_val));
        if (m_axis_tuser_o !== w.word_ovf)
          note_mismatch($sformatf("overflow exp=%0b got=%0b value=%0d", w.word_ovf,
                        m_axis_tuser_o, w.word_val));
      end
    end
  end

  // watchdog on cycles without any word moving
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    sorted_word_t tw;
    int           sent;
    int           batch_len;
    int           batch_idx;
    int           r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    foreach (directed_rows[i]) begin
      tw.word_val  = directed_rows[i].exp_val;
      tw.word_last = directed_rows[i].exp_last;
      tw.word_ovf  = directed_rows[i].exp_ovf;
      send_word(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed, tw);
    end

    tw = '0;
    sent = 0;
    batch_idx = 0;
    while (sent < RANDOM_WORDS) begin
      // a full batch and an overflowing one up front, then mostly short ones
      r = $urandom_range(0, 19);
      if (batch_idx == 0) batch_len = MAX_LEN;
      else if (batch_idx == 1) batch_len = MAX_LEN + 2;
      else if (r == 0) batch_len = $urandom_range(MAX_LEN - 4, MAX_LEN);
      else if (r == 1) batch_len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
      else batch_len = $urandom_range(1, 8);

      if (batch_idx == 3) begin
        s_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge clk_i);
      end

      if (sent >= RANDOM_WORDS - QUIET_WORDS) begin
        quiet = 1'b1;
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end

      for (int k = 0; k < batch_len; k++) begin
        send_word(pick_value(), k == batch_len - 1, 1'b0, tw);
        sent++;
      end
      batch_idx++;
    end
    s_valid <= 1'b0;
    s_last  <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && sorted_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[merge_sort_batch_core.f]
design/mrgs_pkg.sv
design/mrgs_dpath.sv
design/mrgs_ctrl.sv
design/merge_sort_batch_core.sv
verif/tb_top.sv
